>>> src/lmx_pkg.sv
// lmx_pkg: shared types and constants for the lamport mutex node
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps

package lmx_pkg;

    localparam int NODES_DEF      = 5;
    localparam int CLOCK_BITS_DEF = 8;
    localparam int ID_W           = 3;
    localparam int TS_W           = 8;
    localparam int KIND_W         = 3;
    localparam int SEND_W         = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int REPLIES_NEEDED = 2;

    localparam logic [1:0] REPLY_MAX = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CLOCK = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        REQ_LOCAL   = 3'd0,
        REQ_RECV    = 3'd1,
        REQ_REPLY   = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_EXIT    = 3'd4
    } t_req_type;

    typedef enum logic [SEND_W-1:0] {
        SEND_NONE    = 2'd0,
        SEND_REQUEST = 2'd1,
        SEND_REPLY   = 2'd2,
        SEND_RELEASE = 2'd3
    } t_send_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CRIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [ID_W-1:0]   sender_id;
        logic [TS_W-1:0]   msg_timestamp;
    } t_in_item;

    typedef struct packed {
        logic [SEND_W-1:0] send_kind;
        logic [ID_W-1:0]   dest_id;
        logic [TS_W-1:0]   send_timestamp;
        logic              grant;
        logic [TS_W-1:0]   clock_now;
    } t_out_item;

    typedef struct packed {
        logic            put;
        logic            drop;
        logic [ID_W-1:0] who;
    } t_q_ctl;

endpackage

>>> src/lmx_req_if.sv
// lmx_req_if: request channel into the node (valid/ready plus message fields)
// depends on lmx_pkg
`timescale 1ns / 1ps

interface lmx_req_if import lmx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [ID_W-1:0]   sender_id;
    logic [TS_W-1:0]   msg_timestamp;

    modport source (output valid, req_type, sender_id, msg_timestamp, input ready);
    modport sink   (input valid, req_type, sender_id, msg_timestamp, output ready);
endinterface

>>> src/lmx_res_if.sv
// lmx_res_if: result channel out of the node (valid/ready plus send fields)
// depends on lmx_pkg
`timescale 1ns / 1ps

interface lmx_res_if import lmx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEND_W-1:0] send_kind;
    logic [ID_W-1:0]   dest_id;
    logic [TS_W-1:0]   send_timestamp;
    logic              grant;
    logic [TS_W-1:0]   clock_now;

    modport source (output valid, send_kind, dest_id, send_timestamp, grant, clock_now,
                    input ready);
    modport sink   (input valid, send_kind, dest_id, send_timestamp, grant, clock_now,
                    output ready);
endinterface

>>> src/lmx_queue.sv
// lmx_queue: timestamp-ordered request queue, one entry per node id
// depends on lmx_pkg; head check is made on the contents after this update
`timescale 1ns / 1ps

module lmx_queue import lmx_pkg::*; #(
    parameter int NODES   = NODES_DEF,
    parameter int STAMP_W = TS_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_q_ctl             i_ctl,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [ID_W-1:0]    i_node_id,
    input  logic [STAMP_W-1:0] i_own_stamp,
    output logic               o_own_head
);

    logic [NODES-1:0] r_valid;
    logic [ID_W-1:0]  r_node  [NODES];
    logic [STAMP_W-1:0] r_stamp [NODES];

    logic [NODES-1:0] n_valid;
    logic [ID_W-1:0]  n_node  [NODES];
    logic [STAMP_W-1:0] n_stamp [NODES];

    logic [NODES-1:0] hit;
    logic [NODES-1:0] own_match;
    logic [NODES-1:0] ahead;
    logic             free_found;

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            hit[i] = r_valid[i] && (r_node[i] == i_ctl.who);
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_node     = r_node;
        n_stamp    = r_stamp;
        free_found = 1'b0;
        if (i_ctl.put) begin
            if (|hit) begin
                for (int i = 0; i < NODES; i++) begin
                    if (hit[i]) begin
                        n_stamp[i] = i_stamp;
                    end
                end
            end else begin
                for (int i = 0; i < NODES; i++) begin
                    if (!r_valid[i] && !free_found) begin
                        n_valid[i] = 1'b1;
                        n_node[i]  = i_ctl.who;
                        n_stamp[i] = i_stamp;
                        free_found = 1'b1;
                    end
                end
            end
        end
        if (i_ctl.drop) begin
            for (int i = 0; i < NODES; i++) begin
                if (hit[i]) begin
                    n_valid[i] = 1'b0;
                end
            end
        end
    end

    // own entry present and nothing ordered before it
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            own_match[i] = n_valid[i] && (n_node[i] == i_node_id)
                           && (n_stamp[i] == i_own_stamp);
            ahead[i]     = n_valid[i] && (n_node[i] != i_node_id)
                           && ((n_stamp[i] < i_own_stamp)
                               || ((n_stamp[i] == i_own_stamp) && (n_node[i] < i_node_id)));
        end
        o_own_head = (|own_match) && !(|ahead);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_node  <= n_node;
            r_stamp <= n_stamp;
        end
    end

endmodule

>>> src/lamport_mutex_node.sv
// lamport_mutex_node: one node of ring-neighbour Lamport mutual exclusion
// depends on lmx_pkg, lmx_req_if, lmx_res_if and lmx_queue
// The node takes one request per clock cycle when the result side keeps up: an accepted request
// is held in an input register, where the clock update, queue update, head check and phase
// change are all resolved, and its result then moves into an output register. The output
// register frees the input side while a result waits; a stall on the result side holds the
// input register, and then input ready drops. Configuration writes (node id, start clock) take
// effect on the edge they are presented; writing the start clock also loads the Lamport clock.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps

module lamport_mutex_node import lmx_pkg::*; #(
    parameter int NODES      = NODES_DEF,
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lmx_req_if.sink               i_req,
    lmx_res_if.source             o_res
);

    localparam int STAMP_W = (CLOCK_BITS > TS_W) ? CLOCK_BITS : TS_W;
    localparam logic [STAMP_W-1:0] CLK_MAX = STAMP_W'((64'd1 << CLOCK_BITS) - 64'd1);

    t_in_item               r_s1;
    logic                   r_s1_valid;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [CLOCK_BITS-1:0]  r_clock;
    logic [CLOCK_BITS-1:0]  r_own_stamp;
    logic [1:0]             r_reply_cnt;
    t_phase                 r_phase;
    logic [ID_W-1:0]        r_node_id;

    logic [CLOCK_BITS-1:0]  n_clock;
    logic [CLOCK_BITS-1:0]  n_own_stamp;
    logic [1:0]             n_reply_cnt;
    t_phase                 n_phase;
    t_out_item              n_out;

    logic                   adv;
    t_req_type              kind;
    logic [STAMP_W-1:0]     ts_ext;
    logic [STAMP_W-1:0]     clk_ext;
    logic [STAMP_W-1:0]     ts_max;
    logic [STAMP_W-1:0]     ts_inc;
    logic [CLOCK_BITS-1:0]  bumped;
    logic                   is_msg;
    logic [STAMP_W-1:0]     n_clock_ext;
    logic [STAMP_W-1:0]     n_own_ext;
    logic [STAMP_W-1:0]     r_own_ext;
    logic [STAMP_W-1:0]     cfg_clock_ext;
    t_q_ctl                 q_ctl;
    logic [STAMP_W-1:0]     q_stamp;
    logic                   own_head;

    assign adv         = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || adv;

    assign o_res.valid          = r_out_valid;
    assign o_res.send_kind      = r_out.send_kind;
    assign o_res.dest_id        = r_out.dest_id;
    assign o_res.send_timestamp = r_out.send_timestamp;
    assign o_res.grant          = r_out.grant;
    assign o_res.clock_now      = r_out.clock_now;

    assign kind    = t_req_type'(r_s1.req_type);
    assign ts_ext  = STAMP_W'(r_s1.msg_timestamp);
    assign clk_ext = STAMP_W'(r_clock);
    assign ts_max  = (ts_ext > clk_ext) ? ts_ext : clk_ext;
    assign ts_inc  = ts_max + STAMP_W'(1);
    assign bumped  = (ts_max >= CLK_MAX) ? CLK_MAX[CLOCK_BITS-1:0] : ts_inc[CLOCK_BITS-1:0];
    assign is_msg  = (kind == REQ_RECV) || (kind == REQ_REPLY) || (kind == REQ_RELEASE);
    assign n_clock = is_msg ? bumped : r_clock;

    assign n_clock_ext   = STAMP_W'(n_clock);
    assign n_own_ext     = STAMP_W'(n_own_stamp);
    assign r_own_ext     = STAMP_W'(r_own_stamp);
    assign cfg_clock_ext = STAMP_W'(i_cfg_data);

    // next state: phase, own stamp, reply count, queue command
    always_comb begin
        n_phase     = r_phase;
        n_own_stamp = r_own_stamp;
        n_reply_cnt = r_reply_cnt;
        q_ctl       = '0;
        q_stamp     = ts_ext;
        case (kind)
            REQ_LOCAL: begin
                if (r_phase == PH_IDLE) begin
                    n_own_stamp = r_clock;
                    n_reply_cnt = 2'd0;
                    n_phase     = PH_WAIT;
                    q_ctl.put   = 1'b1;
                    q_ctl.who   = r_node_id;
                    q_stamp     = clk_ext;
                end
            end
            REQ_RECV: begin
                q_ctl.put = 1'b1;
                q_ctl.who = r_s1.sender_id;
            end
            REQ_REPLY: begin
                if (r_reply_cnt != REPLY_MAX) begin
                    n_reply_cnt = r_reply_cnt + 2'd1;
                end
            end
            REQ_RELEASE: begin
                q_ctl.drop = 1'b1;
                q_ctl.who  = r_s1.sender_id;
            end
            REQ_EXIT: begin
                if (r_phase == PH_CRIT) begin
                    q_ctl.drop = 1'b1;
                    q_ctl.who  = r_node_id;
                    n_phase    = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
        if ((n_phase == PH_WAIT) && (n_reply_cnt >= 2'(REPLIES_NEEDED)) && own_head) begin
            n_phase = PH_CRIT;
        end
    end

    // outputs: outgoing message of this step
    always_comb begin
        n_out                = '0;
        n_out.send_kind      = SEND_NONE;
        n_out.grant          = (n_phase == PH_CRIT);
        n_out.clock_now      = n_clock_ext[TS_W-1:0];
        case (kind)
            REQ_LOCAL: begin
                if (r_phase == PH_IDLE) begin
                    n_out.send_kind      = SEND_REQUEST;
                    n_out.send_timestamp = clk_ext[TS_W-1:0];
                end
            end
            REQ_RECV: begin
                n_out.send_kind      = SEND_REPLY;
                n_out.dest_id        = r_s1.sender_id;
                n_out.send_timestamp = n_clock_ext[TS_W-1:0];
            end
            REQ_EXIT: begin
                if (r_phase == PH_CRIT) begin
                    n_out.send_kind      = SEND_RELEASE;
                    n_out.send_timestamp = r_own_ext[TS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    lmx_queue #(
        .NODES   (NODES),
        .STAMP_W (STAMP_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_ctl       (q_ctl),
        .i_stamp     (q_stamp),
        .i_node_id   (r_node_id),
        .i_own_stamp (n_own_ext),
        .o_own_head  (own_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clock     <= '0;
            r_own_stamp <= '0;
            r_reply_cnt <= 2'd0;
            r_phase     <= PH_IDLE;
            r_node_id   <= '0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_clock     <= n_clock;
                r_own_stamp <= n_own_stamp;
                r_reply_cnt <= n_reply_cnt;
                r_phase     <= n_phase;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_ID: begin
                        r_node_id <= i_cfg_data[ID_W-1:0];
                    end
                    CFG_START_CLOCK: begin
                        r_clock <= cfg_clock_ext[CLOCK_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1.req_type      <= i_req.req_type;
            r_s1.sender_id     <= i_req.sender_id;
            r_s1.msg_timestamp <= i_req.msg_timestamp;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_crit_has_replies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRIT) |-> (r_reply_cnt >= 2'(REPLIES_NEEDED)))
        else $error("critical phase without enough replies");

    a_crit_leaves_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRIT) |=> ((r_phase == PH_CRIT) || (r_phase == PH_IDLE)))
        else $error("critical phase left to a phase other than idle");

    a_clock_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_we && (i_cfg_idx == CFG_START_CLOCK)) |=> (r_clock >= $past(r_clock)))
        else $error("lamport clock went backward");

    a_recv_gets_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (kind == REQ_RECV)) |=>
            (r_out_valid && (r_out.send_kind == SEND_REPLY)))
        else $error("received request not answered");
`endif

endmodule
